>>> design/sorted_priority_queue_core_assert.svh
// Assertion macros shared by the sorted priority queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define SPQ_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/spq_pkg.sv
// Package with the shared types and codes of the sorted priority queue.
`default_nettype none

package spq_pkg;

	localparam int CAPACITY_DEFAULT = 16;
	localparam int DATA_W = 32;
	localparam int FILL_W = 5;

	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} spq_status_t;

	typedef struct packed {
		logic load_in;
		logic do_enq;
		logic do_deq;
		logic err_empty;
		logic err_full;
	} spq_ctl_t;

	typedef struct packed {
		logic is_deq;
		logic full;
		logic empty;
	} spq_dp_status_t;

endpackage

`default_nettype wire

>>> design/spq_ctrl.sv
// Controller state machine that sequences one queue operation per beat.
`default_nettype none

module spq_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire                     out_ready,
	input  spq_pkg::spq_dp_status_t dp_st,
	output spq_pkg::spq_ctl_t       ctl
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   exec;

	assign exec = (state_q == S_EXEC) && (!out_valid_q || out_ready);
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		ctl.load_in   = in_valid && (state_q == S_IDLE);
		ctl.do_enq    = exec && !dp_st.is_deq && !dp_st.full;
		ctl.do_deq    = exec && dp_st.is_deq && !dp_st.empty;
		ctl.err_empty = exec && dp_st.is_deq && dp_st.empty;
		ctl.err_full  = exec && !dp_st.is_deq && dp_st.full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
					if (out_valid_q && out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				S_EXEC: begin
					if (exec) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> design/spq_dpath.sv
// Datapath with the sorted slot array, the entry count and the result register.
`default_nettype none

module spq_dpath #(
	parameter int CAPACITY = spq_pkg::CAPACITY_DEFAULT
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  spq_pkg::spq_ctl_t                   ctl,
	output spq_pkg::spq_dp_status_t             dp_st,
	input  wire                                 in_cmd,
	input  wire signed [spq_pkg::DATA_W-1:0]    in_value,
	input  wire signed [spq_pkg::DATA_W-1:0]    in_priority,
	output logic signed [spq_pkg::DATA_W-1:0]   out_value,
	output logic signed [spq_pkg::DATA_W-1:0]   out_priority,
	output spq_pkg::spq_status_t                out_status,
	output logic [spq_pkg::FILL_W-1:0]          out_fill
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic                              cmd_q;
	logic signed [spq_pkg::DATA_W-1:0] val_q;
	logic signed [spq_pkg::DATA_W-1:0] pri_q;

	logic signed [spq_pkg::DATA_W-1:0] slot_val_q [CAPACITY];
	logic signed [spq_pkg::DATA_W-1:0] slot_pri_q [CAPACITY];
	logic signed [spq_pkg::DATA_W-1:0] ins_val [CAPACITY];
	logic signed [spq_pkg::DATA_W-1:0] ins_pri [CAPACITY];
	logic [CAPACITY-1:0]               le;

	logic [CW-1:0]                 count_q;
	logic [CW-1:0]                 count_nxt;
	logic [CW+spq_pkg::FILL_W-1:0] count_ext;

	assign dp_st.is_deq = (cmd_q == spq_pkg::CMD_DEQ);
	assign dp_st.full   = (count_q == CW'(CAPACITY));
	assign dp_st.empty  = (count_q == '0);

	// Held entries at or below the new priority form a run from the head.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			le[i] = (CW'(i) < count_q) && (slot_pri_q[i] <= pri_q);
		end
		for (int i = 0; i < CAPACITY; i++) begin
			if (le[i]) begin
				ins_val[i] = slot_val_q[i];
				ins_pri[i] = slot_pri_q[i];
			end else if (i == 0) begin
				ins_val[i] = val_q;
				ins_pri[i] = pri_q;
			end else if (le[(i == 0) ? 0 : i - 1]) begin
				ins_val[i] = val_q;
				ins_pri[i] = pri_q;
			end else begin
				ins_val[i] = slot_val_q[(i == 0) ? 0 : i - 1];
				ins_pri[i] = slot_pri_q[(i == 0) ? 0 : i - 1];
			end
		end
	end

	always_comb begin
		priority if (ctl.do_enq) begin
			count_nxt = count_q + CW'(1);
		end else if (ctl.do_deq) begin
			count_nxt = count_q - CW'(1);
		end else begin
			count_nxt = count_q;
		end
	end

	assign count_ext = {{spq_pkg::FILL_W{1'b0}}, count_nxt};

	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			cmd_q <= in_cmd;
			val_q <= in_value;
			pri_q <= in_priority;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (ctl.do_enq) begin
				slot_val_q[i] <= ins_val[i];
				slot_pri_q[i] <= ins_pri[i];
			end else if (ctl.do_deq && (i < CAPACITY - 1)) begin
				slot_val_q[i] <= slot_val_q[(i < CAPACITY - 1) ? i + 1 : i];
				slot_pri_q[i] <= slot_pri_q[(i < CAPACITY - 1) ? i + 1 : i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.do_enq || ctl.do_deq || ctl.err_empty || ctl.err_full) begin
			out_fill <= count_ext[spq_pkg::FILL_W-1:0];
			if (ctl.do_deq) begin
				out_value    <= slot_val_q[0];
				out_priority <= slot_pri_q[0];
			end else begin
				out_value    <= '0;
				out_priority <= '0;
			end
			priority if (ctl.err_empty) begin
				out_status <= spq_pkg::ST_EMPTY;
			end else if (ctl.err_full) begin
				out_status <= spq_pkg::ST_FULL;
			end else begin
				out_status <= spq_pkg::ST_OK;
			end
		end
	end

endmodule

`default_nettype wire

>>> design/sorted_priority_queue_core.sv
// Top level of the sorted priority queue: controller, datapath and checks.
//
//   Channel  Direction  Beat contents
//   s_*      in         tuser: cmd; tdata: item_value, item_priority
//   m_*      out        tuser: status; tdata: out_value, out_priority, fill_level
//
// Each operation passes through S_IDLE, which captures the beat, and then S_EXEC,
// which updates every slot in parallel from a per-slot priority compare and loads the result.
// The next input beat is taken in the cycle after the result is registered.
// A stalled result holds the update cycle until m_tready is seen.
// After reset the queue is empty at once; no clearing pass is needed.
`default_nettype none

`include "sorted_priority_queue_core_assert.svh"

module sorted_priority_queue_core #(
	parameter int CAPACITY = spq_pkg::CAPACITY_DEFAULT
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [63:0] s_tdata,  // item_value[31:0], item_priority[63:32]
	input  wire         s_tuser,  // cmd[0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [71:0] m_tdata,  // out_value[31:0], out_priority[63:32], fill_level[68:64]
	output logic [1:0]  m_tuser   // status[1:0]
);

	spq_pkg::spq_ctl_t                 ctl;
	spq_pkg::spq_dp_status_t           dp_st;
	logic signed [spq_pkg::DATA_W-1:0] out_value;
	logic signed [spq_pkg::DATA_W-1:0] out_priority;
	spq_pkg::spq_status_t              out_status;
	logic [spq_pkg::FILL_W-1:0]        out_fill;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.dp_st     (dp_st),
		.ctl       (ctl)
	);

	spq_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.dp_st        (dp_st),
		.in_cmd       (s_tuser),
		.in_value     (s_tdata[31:0]),
		.in_priority  (s_tdata[63:32]),
		.out_value    (out_value),
		.out_priority (out_priority),
		.out_status   (out_status),
		.out_fill     (out_fill)
	);

	assign m_tdata = {3'b000, out_fill, out_priority, out_value};
	assign m_tuser = out_status;

	`SPQ_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second beat taken while busy")
	`SPQ_ASSERT_IMPL(a_result_frees_input, $rose(m_tvalid), s_tready, "result loaded but controller still busy")
	`SPQ_ASSERT_IMPL(a_empty_result, m_tvalid && (m_tuser == spq_pkg::ST_EMPTY), (m_tdata[68:0] == 69'd0) && dp_st.empty, "empty result with data or entries")
	`SPQ_ASSERT_IMPL(a_full_result, m_tvalid && (m_tuser == spq_pkg::ST_FULL), dp_st.full && (m_tdata[63:0] == 64'd0), "full result while queue not full")

endmodule

`default_nettype wire

>>> verif/spq_result_monitor.sv
// Watches both channels of the sorted priority queue, predicts each result and compares it.
module spq_result_monitor
	import spq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEFAULT
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	input  wire         s_tready,
	input  wire  [63:0] s_tdata,  // item_value[31:0], item_priority[63:32]
	input  wire         s_tuser,  // cmd[0]
	input  wire         m_tvalid,
	input  wire         m_tready,
	input  wire  [71:0] m_tdata,  // out_value[31:0], out_priority[63:32], fill_level[68:64]
	input  wire  [1:0]  m_tuser,  // status[1:0]
	output int          fail_count,
	output int          pending_count,
	output int          op_count,
	output int          removed_count,
	output int          empty_count,
	output int          full_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] prio;
		spq_status_t              status;
		logic [FILL_W-1:0]        fill;
	} queue_result_t;

	logic signed [DATA_W-1:0] held_value [CAPACITY];
	logic signed [DATA_W-1:0] held_prio [CAPACITY];
	int unsigned              held_count;
	queue_result_t            awaited_results [$];

	function automatic queue_result_t next_queue_result(input logic cmd,
			input logic signed [DATA_W-1:0] value, input logic signed [DATA_W-1:0] prio);
		queue_result_t r;
		int unsigned   pos;
		r = '0;
		r.status = ST_OK;
		if (cmd == CMD_ENQ) begin
			if (held_count >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				pos = 0;
				while (pos < held_count && held_prio[pos] <= prio)
					pos++;
				for (int unsigned i = held_count; i > pos; i--) begin
					held_value[i] = held_value[i-1];
					held_prio[i] = held_prio[i-1];
				end
				held_value[pos] = value;
				held_prio[pos] = prio;
				held_count++;
			end
		end else begin
			if (held_count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.value = held_value[0];
				r.prio = held_prio[0];
				for (int unsigned i = 1; i < held_count; i++) begin
					held_value[i-1] = held_value[i];
					held_prio[i-1] = held_prio[i];
				end
				held_count--;
			end
		end
		r.fill = held_count[FILL_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		queue_result_t want;
		logic signed [DATA_W-1:0] got_value;
		logic signed [DATA_W-1:0] got_prio;
		if (!arst_n) begin
			held_count = 0;
			awaited_results.delete();
			fail_count = 0;
			pending_count = 0;
			op_count = 0;
			removed_count = 0;
			empty_count = 0;
			full_count = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				want = next_queue_result(s_tuser, s_tdata[31:0], s_tdata[63:32]);
				awaited_results.push_back(want);
				op_count++;
				if (want.status == ST_FULL)
					full_count++;
				else if (want.status == ST_EMPTY)
					empty_count++;
				else if (s_tuser == CMD_DEQ)
					removed_count++;
			end
			if (m_tvalid && m_tready) begin
				got_value = m_tdata[31:0];
				got_prio = m_tdata[63:32];
				if (awaited_results.size() == 0) begin
					$error("result beat with no operation outstanding: status %0d fill %0d",
						m_tuser, m_tdata[68:64]);
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					if (m_tuser !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_tuser);
						fail_count++;
					end
					if (got_value !== want.value) begin
						$error("out_value: expected %0d, got %0d", want.value, got_value);
						fail_count++;
					end
					if (got_prio !== want.prio) begin
						$error("out_priority: expected %0d, got %0d", want.prio, got_prio);
						fail_count++;
					end
					if (m_tdata[68:64] !== want.fill) begin
						$error("fill_level: expected %0d, got %0d", want.fill, m_tdata[68:64]);
						fail_count++;
					end
				end
			end
			pending_count = awaited_results.size();
		end
	end

endmodule

>>> verif/sorted_priority_queue_core_test.sv
// Top of the sorted priority queue testbench: clock, reset, beat traffic and verdict.
module sorted_priority_queue_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import spq_pkg::*;

	localparam int RANDOM_OPS = 1628;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	logic [1:0]  m_tuser;

	int fail_count;
	int pending_count;
	int op_count;
	int removed_count;
	int empty_count;
	int full_count;
	int cycle_count;
	int hold_left;

	bit tx_gaps_on;
	bit rx_gaps_on;
	bit hold_go;

	sorted_priority_queue_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	spq_result_monitor u_monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.op_count      (op_count),
		.removed_count (removed_count),
		.empty_count   (empty_count),
		.full_count    (full_count)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d results outstanding.",
				cycle_count, pending_count);
			$display("sorted_priority_queue_core_test: FAIL");
			$finish;
		end
	end

	initial begin
		m_tready = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_go) begin
				hold_go = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= rx_gaps_on ? ($urandom_range(99) >= 38) : 1'b1;
			end
		end
	end

	task automatic send_op(input logic cmd, input logic [31:0] value, input logic [31:0] prio);
		while (tx_gaps_on && $urandom_range(99) < 38) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {prio, value};
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_priority();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 40)
			return 32'($signed($urandom_range(7)) - 3);
		if (roll < 90)
			return $urandom;
		case ($urandom_range(3))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			default: return 32'hffff_ffff;
		endcase
	endfunction

	initial begin
		int unsigned enq_bias;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_ENQ;
		hold_go = 1'b0;
		tx_gaps_on = 1'b1;
		rx_gaps_on = 1'b1;
		cycle_count = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty dequeue, overfill with extreme and tied priorities, then four dequeues.
		send_op(CMD_DEQ, 32'h1234_5678, 32'h8765_4321);
		send_op(CMD_ENQ, 32'h0000_0000, 32'h7fff_ffff);
		send_op(CMD_ENQ, 32'hffff_ffff, 32'h8000_0000);
		send_op(CMD_ENQ, 32'h7fff_ffff, 32'h0000_0000);
		send_op(CMD_ENQ, 32'h8000_0000, 32'hffff_ffff);
		send_op(CMD_ENQ, 32'haaaa_aaaa, 32'h0000_0005);
		send_op(CMD_ENQ, 32'h5555_5555, 32'h0000_0005);
		send_op(CMD_ENQ, 32'h0000_0001, 32'h0000_0005);
		send_op(CMD_ENQ, 32'h0000_0002, 32'hffff_ffff);
		send_op(CMD_ENQ, 32'h0000_0003, 32'h7fff_ffff);
		send_op(CMD_ENQ, 32'h0000_0004, 32'h8000_0000);
		send_op(CMD_ENQ, 32'hdead_beef, 32'h0000_0001);
		send_op(CMD_ENQ, 32'hcafe_f00d, 32'h4000_0000);
		send_op(CMD_ENQ, 32'h0bad_c0de, 32'hc000_0000);
		send_op(CMD_ENQ, $urandom, $urandom);
		send_op(CMD_ENQ, $urandom, $urandom);
		send_op(CMD_ENQ, $urandom, 32'h0000_0000);
		send_op(CMD_ENQ, 32'hffff_ffff, 32'h8000_0000);
		repeat (4)
			send_op(CMD_DEQ, $urandom, $urandom);

		// The enqueue share swings per block so the queue runs between empty and full.
		enq_bias = 50;
		for (int n = 0; n < RANDOM_OPS; n++) begin
			if (n % 64 == 0)
				enq_bias = ($urandom_range(2) == 0) ? 20 : ($urandom_range(1) ? 80 : 50);
			tx_gaps_on = !(n >= 300 && n < 700);
			rx_gaps_on = tx_gaps_on;
			if (n == 900)
				hold_go = 1'b1;
			if ($urandom_range(99) < enq_bias)
				send_op(CMD_ENQ, $urandom, pick_priority());
			else
				send_op(CMD_DEQ, $urandom, $urandom);
		end
		s_tvalid <= 1'b0;

		while (pending_count != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Ran %0d operations: %0d entries removed in order, %0d dequeues on empty,",
			op_count, removed_count, empty_count);
		$display("%0d enqueues dropped while full, %0d mismatches.", full_count, fail_count);
		if (fail_count == 0)
			$display("sorted_priority_queue_core_test: PASS");
		else
			$display("sorted_priority_queue_core_test: FAIL");
		$finish;
	end

endmodule

>>> sorted_priority_queue_core.f
+incdir+design
design/spq_pkg.sv
design/spq_ctrl.sv
design/spq_dpath.sv
design/sorted_priority_queue_core.sv
verif/spq_result_monitor.sv
verif/sorted_priority_queue_core_test.sv
